// ===== hw/rtl/urf_pkg.sv =====
// Package for the ultrasonic range finder core.
// Holds field widths, timing constants, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urf_pkg;

  // Field and state widths.
  localparam int unsigned TIMEOUT_W  = 15;
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned HOLD_W     = 13;
  localparam int unsigned CM_W       = 10;
  localparam int unsigned WIDTH_W    = 15;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned PRESCALE_W = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Timing constants.
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_CAP_US = 15'd30000;
  localparam logic [PRESCALE_W-1:0] US_PER_MS      = 10'd1000;
  localparam logic [WIDTH_W-1:0]    TRIG_LOW_TICKS  = 15'd2;
  localparam logic [WIDTH_W-1:0]    TRIG_HIGH_TICKS = 15'd10;
  localparam logic [CM_W-1:0]       NO_DISTANCE    = 10'd999;

  // Divide by 58 through a reciprocal: exact for every width below 2^17.
  localparam int unsigned US_PER_CM   = 58;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((2 ** RECIP_SHIFT) + US_PER_CM - 1) / US_PER_CM);

  // Register reset values.
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 15'd30000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd80;
  localparam logic [HOLD_W-1:0]     HOLD_RST     = 13'd450;
  localparam logic [CM_W-1:0]       MIN_CM_RST   = 10'd2;
  localparam logic [CM_W-1:0]       MAX_CM_RST   = 10'd400;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CM   = 3'd4;

  // Distance that is reported between readings.
  typedef struct packed {
    logic [CM_W-1:0] distance;
    logic            ok;
  } held_t;

  // Range limits handed to the reading evaluator.
  typedef struct packed {
    logic [CM_W-1:0]   min_cm;
    logic [CM_W-1:0]   max_cm;
    logic [HOLD_W-1:0] hold_ms;
  } limits_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ultrasonic_range_finder_core.sv =====
// Top level of the ultrasonic range finder: trigger sequencer, echo timing,
// millisecond time base and result register. Depends on urf_pkg, urf_eval.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                    Beat
// in_       input      in_valid, in_ready, in_echo_level          one microsecond tick
// out_      output     out_valid, out_ready, out_trigger_level,   one result per tick
//                      out_distance_cm, out_reading_ok,
//                      out_echo_width_us, out_reading_done
// cfg_      input      cfg_we, cfg_index, cfg_wdata               one register write
//
// Every input beat yields one result beat in the cycle after it is accepted; a
// beat can be taken in every cycle unless a result waits and is not taken in the
// same cycle. The sequencer state and the result register update together when a
// beat is accepted, so the rate is set by the single result register. Reset is
// synchronous and restores all registers to their defaults.

module ultrasonic_range_finder_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_echo_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_trigger_level,
  output logic [urf_pkg::CM_W-1:0]               out_distance_cm,
  output logic                                   out_reading_ok,
  output logic [urf_pkg::WIDTH_W-1:0]            out_echo_width_us,
  output logic                                   out_reading_done,
  input  wire logic                              cfg_we,
  input  wire logic [urf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [urf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_END,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_t;

  // Configuration registers.
  logic [urf_pkg::TIMEOUT_W-1:0]  timeout_r;
  logic [urf_pkg::INTERVAL_W-1:0] interval_r;
  logic [urf_pkg::HOLD_W-1:0]     hold_r;
  logic [urf_pkg::CM_W-1:0]       min_cm_r;
  logic [urf_pkg::CM_W-1:0]       max_cm_r;

  // Sequencer and time base state.
  phase_t                          phase_r, phase_nxt;
  logic [urf_pkg::WIDTH_W-1:0]     timer_r, timer_nxt;
  logic [urf_pkg::WIDTH_W-1:0]     width_r, width_nxt;
  logic [urf_pkg::WIDTH_W-1:0]     last_width_r, last_width_nxt;
  logic [urf_pkg::PRESCALE_W-1:0]  prescale_r, prescale_nxt;
  logic [urf_pkg::MS_W-1:0]        ms_now_r, ms_now_nxt;
  logic [urf_pkg::MS_W-1:0]        start_ms_r, start_ms_nxt;
  logic [urf_pkg::MS_W-1:0]        valid_ms_r, valid_ms_nxt;
  urf_pkg::held_t                  held_r, held_nxt, held_eval;
  logic [urf_pkg::MS_W-1:0]        valid_ms_eval;

  // Result register.
  logic                            out_valid_r;
  logic                            trig_r;
  logic                            done_r;

  logic                            accept;
  logic                            trig;
  logic                            finish;
  logic [urf_pkg::WIDTH_W-1:0]     fin_width;
  logic [urf_pkg::WIDTH_W-1:0]     limit;
  logic [urf_pkg::WIDTH_W-1:0]     timer_inc;
  logic [urf_pkg::PRESCALE_W-1:0]  prescale_inc;
  urf_pkg::limits_t                limits;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Zero or out-of-range timeout falls back to the cap.
  assign limit = ((timeout_r == '0) || (timeout_r > urf_pkg::TIMEOUT_CAP_US)) ?
                 urf_pkg::TIMEOUT_CAP_US : timeout_r;

  assign timer_inc = timer_r + 1'b1;

  // Trigger and echo sequencer.
  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    width_nxt    = width_r;
    start_ms_nxt = start_ms_r;
    trig         = 1'b0;
    finish       = 1'b0;
    fin_width    = width_r;
    case (phase_r)
      PH_IDLE: begin
        if ((ms_now_r - start_ms_r) >= urf_pkg::MS_W'(interval_r)) begin
          start_ms_nxt = ms_now_r;
          phase_nxt    = PH_TRIG_LOW;
          timer_nxt    = urf_pkg::WIDTH_W'(1);
        end
      end
      PH_TRIG_LOW: begin
        if (timer_r >= urf_pkg::TRIG_LOW_TICKS) begin
          phase_nxt = PH_TRIG_HIGH;
          timer_nxt = urf_pkg::WIDTH_W'(1);
          trig      = 1'b1;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      PH_TRIG_HIGH: begin
        if (timer_r >= urf_pkg::TRIG_HIGH_TICKS) begin
          phase_nxt = PH_WAIT_END;
          timer_nxt = '0;
          width_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
          trig      = 1'b1;
        end
      end
      PH_WAIT_END, PH_WAIT_RISE, PH_MEASURE: begin
        timer_nxt = timer_inc;
        if (phase_r == PH_WAIT_END) begin
          if (!in_echo_level) phase_nxt = PH_WAIT_RISE;
        end else if (phase_r == PH_WAIT_RISE) begin
          if (in_echo_level) begin
            phase_nxt = PH_MEASURE;
            width_nxt = urf_pkg::WIDTH_W'(1);
          end
        end else begin
          if (in_echo_level) begin
            width_nxt = width_r + 1'b1;
          end else begin
            finish    = 1'b1;
            fin_width = width_r;
          end
        end
        // The window covers all three echo phases; a fall on its last tick wins.
        if (!finish && (timer_inc >= limit)) begin
          finish    = 1'b1;
          fin_width = '0;
        end
        if (finish) begin
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
          width_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
      end
    endcase
  end

  // Reading evaluation.
  assign limits.min_cm  = min_cm_r;
  assign limits.max_cm  = max_cm_r;
  assign limits.hold_ms = hold_r;

  urf_eval u_eval (
    .width        (fin_width),
    .start_ms     (start_ms_r),
    .valid_ms     (valid_ms_r),
    .held         (held_r),
    .limits       (limits),
    .held_nxt     (held_eval),
    .valid_ms_nxt (valid_ms_eval)
  );

  assign held_nxt       = finish ? held_eval : held_r;
  assign valid_ms_nxt   = finish ? valid_ms_eval : valid_ms_r;
  assign last_width_nxt = finish ? fin_width : last_width_r;

  // Millisecond time base, advanced after the sequencer on every tick.
  assign prescale_inc = prescale_r + 1'b1;
  always_comb begin
    if (prescale_inc >= urf_pkg::US_PER_MS) begin
      prescale_nxt = '0;
      ms_now_nxt   = ms_now_r + 1'b1;
    end else begin
      prescale_nxt = prescale_inc;
      ms_now_nxt   = ms_now_r;
    end
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= urf_pkg::TIMEOUT_RST;
      interval_r   <= urf_pkg::INTERVAL_RST;
      hold_r       <= urf_pkg::HOLD_RST;
      min_cm_r     <= urf_pkg::MIN_CM_RST;
      max_cm_r     <= urf_pkg::MAX_CM_RST;
      phase_r      <= PH_IDLE;
      timer_r      <= '0;
      width_r      <= '0;
      last_width_r <= '0;
      prescale_r   <= '0;
      ms_now_r     <= '0;
      start_ms_r   <= '0;
      valid_ms_r   <= '0;
      held_r       <= '{distance: urf_pkg::NO_DISTANCE, ok: 1'b0};
      out_valid_r  <= 1'b0;
      trig_r       <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          urf_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata[urf_pkg::TIMEOUT_W-1:0];
          urf_pkg::REG_INTERVAL: interval_r <= cfg_wdata[urf_pkg::INTERVAL_W-1:0];
          urf_pkg::REG_HOLD:     hold_r     <= cfg_wdata[urf_pkg::HOLD_W-1:0];
          urf_pkg::REG_MIN_CM:   min_cm_r   <= cfg_wdata[urf_pkg::CM_W-1:0];
          urf_pkg::REG_MAX_CM:   max_cm_r   <= cfg_wdata[urf_pkg::CM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_r      <= phase_nxt;
        timer_r      <= timer_nxt;
        width_r      <= width_nxt;
        last_width_r <= last_width_nxt;
        prescale_r   <= prescale_nxt;
        ms_now_r     <= ms_now_nxt;
        start_ms_r   <= start_ms_nxt;
        valid_ms_r   <= valid_ms_nxt;
        held_r       <= held_nxt;
        trig_r       <= trig;
        done_r       <= finish;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // The held distance and width registers double as the result payload.
  assign out_valid         = out_valid_r;
  assign out_trigger_level = trig_r;
  assign out_distance_cm   = held_r.distance;
  assign out_reading_ok    = held_r.ok;
  assign out_echo_width_us = last_width_r;
  assign out_reading_done  = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/urf_eval.sv =====
// Reading evaluator: converts an echo width to centimeters and decides the
// new reported distance and hold time stamp. Depends on urf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urf_eval (
  input  wire logic [urf_pkg::WIDTH_W-1:0] width,
  input  wire logic [urf_pkg::MS_W-1:0]    start_ms,
  input  wire logic [urf_pkg::MS_W-1:0]    valid_ms,
  input  wire urf_pkg::held_t              held,
  input  wire urf_pkg::limits_t            limits,
  output urf_pkg::held_t                   held_nxt,
  output logic [urf_pkg::MS_W-1:0]         valid_ms_nxt
);

  localparam int unsigned PROD_W = urf_pkg::WIDTH_W + urf_pkg::RECIP_W;

  logic [PROD_W-1:0]             product;
  logic [urf_pkg::CM_W-1:0]      cm;
  logic [urf_pkg::MS_W-1:0]      since_valid;
  logic                          in_range;
  logic                          still_held;

  // Width / 58 as a multiply by the reciprocal and a shift.
  assign product = PROD_W'(width) * PROD_W'(urf_pkg::RECIP_MULT);
  assign cm      = urf_pkg::CM_W'(product >> urf_pkg::RECIP_SHIFT);

  // A zero width never counts, whatever the lower limit is.
  assign in_range = (width != '0) && (cm >= limits.min_cm) && (cm <= limits.max_cm);

  // The hold runs from the start of the last valid measurement.
  assign since_valid = start_ms - valid_ms;
  assign still_held  = held.ok &&
                       (since_valid <= urf_pkg::MS_W'(limits.hold_ms));

  always_comb begin
    held_nxt     = held;
    valid_ms_nxt = valid_ms;
    if (in_range) begin
      held_nxt.distance = cm;
      held_nxt.ok       = 1'b1;
      valid_ms_nxt      = start_ms;
    end else if (!still_held) begin
      held_nxt.distance = urf_pkg::NO_DISTANCE;
      held_nxt.ok       = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for ultrasonic_range_finder_core: a short table of directed ticks, then
// phases of random echo waveforms, every result beat checked against its table row or an in-bench ranger model.
// Depends on urf_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned DRAIN_SLACK     = 8;
  localparam int unsigned PRESSURE_AFTER  = 600;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned MAX_PRINTED     = 100;

  // An index past the register list; the core must ignore writes to it.
  localparam logic [urf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_TRIG_LOW,
    SEQ_TRIG_HIGH,
    SEQ_WAIT_END,
    SEQ_WAIT_RISE,
    SEQ_MEASURE
  } seq_phase_t;

  typedef struct packed {
    logic                        trigger;
    logic [urf_pkg::CM_W-1:0]    distance;
    logic                        ok;
    logic [urf_pkg::WIDTH_W-1:0] width;
    logic                        done;
  } ranger_out_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [urf_pkg::CFG_IDX_W-1:0]  index;
    logic [urf_pkg::CFG_DATA_W-1:0] data;
    logic                           echo;
    logic                           typed;
    ranger_out_t                    want;
  } table_row_t;

  typedef struct packed {
    int unsigned                    ticks;
    logic [urf_pkg::CFG_DATA_W-1:0] timeout;
    logic [urf_pkg::CFG_DATA_W-1:0] interval;
    logic [urf_pkg::CFG_DATA_W-1:0] hold;
    logic [urf_pkg::CFG_DATA_W-1:0] min_cm;
    logic [urf_pkg::CFG_DATA_W-1:0] max_cm;
    int unsigned                    low_min;
    int unsigned                    low_max;
    int unsigned                    high_min;
    int unsigned                    high_max;
  } echo_phase_t;

  localparam ranger_out_t QUIET_OUT = '{1'b0, urf_pkg::NO_DISTANCE, 1'b0, 15'd0, 1'b0};
  localparam ranger_out_t TIMED_OUT = '{1'b0, urf_pkg::NO_DISTANCE, 1'b0, 15'd0, 1'b1};

  // Two idle ticks under the reset settings, then a back-to-back setup with a one-tick
  // window and a zero minimum, so the first measurement times out with zero width.
  localparam table_row_t OPENING_ROWS [20] = '{
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b0, 1'b1, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b1, QUIET_OUT},
    '{ROW_WRITE, urf_pkg::REG_INTERVAL, 15'd0,      1'b0, 1'b0, QUIET_OUT},
    '{ROW_WRITE, urf_pkg::REG_TIMEOUT,  15'd1,      1'b0, 1'b0, QUIET_OUT},
    '{ROW_WRITE, urf_pkg::REG_MIN_CM,   15'h7C00,   1'b0, 1'b0, QUIET_OUT},
    '{ROW_WRITE, REG_UNUSED,            15'h7FFF,   1'b0, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b0, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b0, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b0, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b0, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b0, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b0, QUIET_OUT},
    '{ROW_TICK,  urf_pkg::REG_TIMEOUT,  15'd0,      1'b1, 1'b1, TIMED_OUT}
  };

  // Settings and echo run lengths per random phase: timeout, interval, hold, min, max.
  // Covers edges that land on the window end, the cap and values above it, min above
  // max, zero hold across a millisecond boundary, and a long interval.
  localparam echo_phase_t ECHO_PHASES [7] = '{
    '{250, 15'd3,     15'd0,    15'd0,    15'd0,   15'd999, 1, 4,  1,   4},
    '{300, 15'd0,     15'd0,    15'd5000, 15'd1,   15'd5,   1, 20, 30,  400},
    '{250, 15'd32767, 15'd0,    15'd0,    15'd3,   15'd2,   1, 30, 100, 300},
    '{400, 15'd60,    15'd0,    15'd0,    15'd0,   15'd1,   1, 90, 1,   90},
    '{250, 15'd200,   15'd1,    15'd2,    15'd0,   15'd999, 1, 50, 1,   150},
    '{100, 15'd30000, 15'd1000, 15'd5000, 15'd999, 15'd999, 1, 10, 1,   10},
    '{300, 15'd30000, 15'd0,    15'd450,  15'd2,   15'd400, 1, 10, 116, 250}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_echo_level;
  logic                           out_valid;
  logic                           out_ready;
  logic                           out_trigger_level;
  logic [urf_pkg::CM_W-1:0]       out_distance_cm;
  logic                           out_reading_ok;
  logic [urf_pkg::WIDTH_W-1:0]    out_echo_width_us;
  logic                           out_reading_done;
  logic                           cfg_we;
  logic [urf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [urf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ultrasonic_range_finder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_distance_cm   (out_distance_cm),
    .out_reading_ok    (out_reading_ok),
    .out_echo_width_us (out_echo_width_us),
    .out_reading_done  (out_reading_done),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Ranger model state and its copy of the registers.
  logic [urf_pkg::PRESCALE_W-1:0] us_count;
  logic [urf_pkg::MS_W-1:0]       ms_count;
  logic [urf_pkg::MS_W-1:0]       start_ms;
  logic [urf_pkg::MS_W-1:0]       valid_ms;
  seq_phase_t                     seq_phase;
  logic [urf_pkg::WIDTH_W-1:0]    seq_timer;
  logic [urf_pkg::WIDTH_W-1:0]    high_count;
  logic [urf_pkg::WIDTH_W-1:0]    last_width;
  logic [urf_pkg::CM_W-1:0]       shown_distance;
  logic                           shown_ok;
  logic [urf_pkg::TIMEOUT_W-1:0]  timeout_reg;
  logic [urf_pkg::INTERVAL_W-1:0] interval_reg;
  logic [urf_pkg::HOLD_W-1:0]     hold_reg;
  logic [urf_pkg::CM_W-1:0]       min_cm_reg;
  logic [urf_pkg::CM_W-1:0]       max_cm_reg;

  ranger_out_t results_due [$];
  ranger_out_t oldest_due;
  int unsigned ticks_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  logic        source_steady = 1'b0;

  function automatic void reset_ranger();
    us_count       = '0;
    ms_count       = '0;
    start_ms       = '0;
    valid_ms       = '0;
    seq_phase      = SEQ_IDLE;
    seq_timer      = '0;
    high_count     = '0;
    last_width     = '0;
    shown_distance = urf_pkg::NO_DISTANCE;
    shown_ok       = 1'b0;
    timeout_reg    = urf_pkg::TIMEOUT_RST;
    interval_reg   = urf_pkg::INTERVAL_RST;
    hold_reg       = urf_pkg::HOLD_RST;
    min_cm_reg     = urf_pkg::MIN_CM_RST;
    max_cm_reg     = urf_pkg::MAX_CM_RST;
  endfunction

  // A finished measurement: a valid distance is latched, otherwise the held one
  // survives only while its start lies within the hold time.
  function automatic void settle_reading(logic [urf_pkg::WIDTH_W-1:0] width);
    int unsigned              cm;
    logic [urf_pkg::MS_W-1:0] since_valid;
    last_width = width;
    cm = width / urf_pkg::US_PER_CM;
    if (width != 0 && cm >= min_cm_reg && cm <= max_cm_reg) begin
      shown_distance = urf_pkg::CM_W'(cm);
      shown_ok       = 1'b1;
      valid_ms       = start_ms;
    end else begin
      since_valid = start_ms - valid_ms;
      if (!(shown_ok && since_valid <= urf_pkg::MS_W'(hold_reg))) begin
        shown_ok       = 1'b0;
        shown_distance = urf_pkg::NO_DISTANCE;
      end
    end
  endfunction

  // One microsecond tick of the ranger; returns the result beat it produces.
  function automatic ranger_out_t advance_ranger(logic echo);
    ranger_out_t                 res;
    logic [urf_pkg::WIDTH_W-1:0] window;
    logic                        finished;
    res      = '0;
    finished = 1'b0;
    window   = (timeout_reg == 0 || timeout_reg > urf_pkg::TIMEOUT_CAP_US) ?
               urf_pkg::TIMEOUT_CAP_US : timeout_reg;
    case (seq_phase)
      SEQ_IDLE: begin
        if (ms_count - start_ms >= urf_pkg::MS_W'(interval_reg)) begin
          start_ms  = ms_count;
          seq_phase = SEQ_TRIG_LOW;
          seq_timer = urf_pkg::WIDTH_W'(1);
        end
      end
      SEQ_TRIG_LOW: begin
        if (seq_timer >= urf_pkg::TRIG_LOW_TICKS) begin
          seq_phase   = SEQ_TRIG_HIGH;
          seq_timer   = urf_pkg::WIDTH_W'(1);
          res.trigger = 1'b1;
        end else begin
          seq_timer++;
        end
      end
      SEQ_TRIG_HIGH: begin
        if (seq_timer >= urf_pkg::TRIG_HIGH_TICKS) begin
          seq_phase  = SEQ_WAIT_END;
          seq_timer  = '0;
          high_count = '0;
        end else begin
          seq_timer++;
          res.trigger = 1'b1;
        end
      end
      default: begin
        // Every echo tick counts against the window, whatever the sub-phase.
        seq_timer++;
        case (seq_phase)
          SEQ_WAIT_END: begin
            if (!echo) seq_phase = SEQ_WAIT_RISE;
          end
          SEQ_WAIT_RISE: begin
            if (echo) begin
              seq_phase  = SEQ_MEASURE;
              high_count = urf_pkg::WIDTH_W'(1);
            end
          end
          default: begin
            if (echo) begin
              high_count++;
            end else begin
              settle_reading(high_count);
              finished = 1'b1;
            end
          end
        endcase
        if (!finished && seq_timer >= window) begin
          settle_reading('0);
          finished = 1'b1;
        end
        if (finished) begin
          res.done   = 1'b1;
          seq_phase  = SEQ_IDLE;
          seq_timer  = '0;
          high_count = '0;
        end
      end
    endcase
    us_count++;
    if (us_count >= urf_pkg::US_PER_MS) begin
      us_count = '0;
      ms_count++;
    end
    res.distance = shown_distance;
    res.ok       = shown_ok;
    res.width    = last_width;
    return res;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(15, 60);
  endfunction

  task automatic report_error(string msg);
    if (errors < MAX_PRINTED) $display("ERROR: %s", msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("beat %0d %s: got %0d, expected %0d",
                             beats_checked, name, got, want));
    end
  endtask

  // Offer one tick, with an optional gap in front, and record its expected result.
  task automatic send_tick(logic echo, logic typed, ranger_out_t want);
    int unsigned gap;
    ranger_out_t predicted;
    gap = (source_steady || $urandom_range(0, 3) != 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    predicted = advance_ranger(echo);
    results_due.push_back(typed ? want : predicted);
    ticks_sent++;
    if ($urandom_range(0, 99) == 0) source_steady = !source_steady;
  endtask

  // Stop offering ticks and let every expected beat come out.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [urf_pkg::CFG_IDX_W-1:0] index,
                           logic [urf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    case (index)
      urf_pkg::REG_TIMEOUT:  timeout_reg  = data[urf_pkg::TIMEOUT_W-1:0];
      urf_pkg::REG_INTERVAL: interval_reg = data[urf_pkg::INTERVAL_W-1:0];
      urf_pkg::REG_HOLD:     hold_reg     = data[urf_pkg::HOLD_W-1:0];
      urf_pkg::REG_MIN_CM:   min_cm_reg   = data[urf_pkg::CM_W-1:0];
      urf_pkg::REG_MAX_CM:   max_cm_reg   = data[urf_pkg::CM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Result side: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_error($sformatf("beat %0d arrived with nothing expected", beats_checked));
      end else begin
        oldest_due = results_due.pop_front();
        check_field("trigger_level", 32'(out_trigger_level), 32'(oldest_due.trigger));
        check_field("distance_cm", 32'(out_distance_cm), 32'(oldest_due.distance));
        check_field("reading_ok", 32'(out_reading_ok), 32'(oldest_due.ok));
        check_field("echo_width_us", 32'(out_echo_width_us), 32'(oldest_due.width));
        check_field("reading_done", 32'(out_reading_done), 32'(oldest_due.done));
      end
      beats_checked++;
    end
  end

  // Receiver: random stalls, steady stretches, and one long hold-off once traffic
  // is flowing so the result register fills and the input backs up.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    logic        sink_steady;
    logic        pressure_done;
    stall_left    = 0;
    hold_left     = 0;
    sink_steady   = 1'b0;
    pressure_done = 1'b0;
    out_ready     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!pressure_done && ticks_sent >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES - 1;
        out_ready     <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (sink_steady || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = idle_len() - 1;
        out_ready  <= 1'b0;
      end
      if ($urandom_range(0, 99) == 0) sink_steady = !sink_steady;
    end
  end

  // Stimulus: reset, the directed table, then the random echo phases.
  initial begin
    table_row_t  row;
    echo_phase_t plan;
    logic        echo_high;
    int unsigned run_left;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_echo_level = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = urf_pkg::REG_TIMEOUT;
    cfg_wdata     = '0;
    echo_high     = 1'b0;
    run_left      = 0;
    reset_ranger();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(OPENING_ROWS); i++) begin
      row = OPENING_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        quiesce();
        write_reg(row.index, row.data);
      end else begin
        send_tick(row.echo, row.typed, row.want);
      end
    end

    // Echo as alternating low and high runs; one tick in ten is a random level
    // that breaks up the pulse.
    for (int p = 0; p < $size(ECHO_PHASES); p++) begin
      plan = ECHO_PHASES[p];
      quiesce();
      write_reg(urf_pkg::REG_TIMEOUT, plan.timeout);
      write_reg(urf_pkg::REG_INTERVAL, plan.interval);
      write_reg(urf_pkg::REG_HOLD, plan.hold);
      write_reg(urf_pkg::REG_MIN_CM, plan.min_cm);
      write_reg(urf_pkg::REG_MAX_CM, plan.max_cm);
      for (int t = 0; t < plan.ticks; t++) begin
        if (run_left == 0) begin
          echo_high = !echo_high;
          run_left  = echo_high ? $urandom_range(plan.high_min, plan.high_max)
                                : $urandom_range(plan.low_min, plan.low_max);
        end
        run_left--;
        if ($urandom_range(0, 9) == 0) begin
          send_tick(1'($urandom), 1'b0, QUIET_OUT);
        end else begin
          send_tick(echo_high, 1'b0, QUIET_OUT);
        end
      end
    end

    quiesce();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/urf_pkg.sv
hw/rtl/urf_eval.sv
hw/rtl/ultrasonic_range_finder_core.sv
tb/sv/testbench.sv
